>>> src/frwg_pkg.sv
// Shared types and constants for the fuzzy rule weight generator.
`timescale 1ns / 1ps

package frwg_pkg;

   localparam int SAMPLE_W = 16;
   localparam int BP_W     = 64;
   localparam int PEAK_W   = 16;
   localparam int DEG_W    = 17;
   localparam int Q_BITS   = 16;
   localparam int IDX_W    = 6;
   localparam int WEIGHT_W = 17;
   localparam int N_INPUTS = 3;
   localparam int CSR_W    = 2;

   localparam logic [DEG_W-1:0] ONE_Q16  = DEG_W'(65536);
   localparam logic [BP_W-1:0]  BP_RESET = 64'h0003_0002_0001_0000;

   localparam logic [CSR_W-1:0] CSR_BP_FIRST  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_BP_SECOND = 2'd1;
   localparam logic [CSR_W-1:0] CSR_BP_THIRD  = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } lane_status_type;

endpackage

>>> src/frwg_lane.sv
// One fuzzification lane: clamps a sample and computes its set degrees.
`timescale 1ns / 1ps

module frwg_lane #(
   parameter int N_SETS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               take,
   input  logic [frwg_pkg::BP_W-1:0]          breakpoints,
   input  logic signed [frwg_pkg::SAMPLE_W-1:0] sample,
   output logic [frwg_pkg::DEG_W-1:0]         degree [N_SETS],
   output frwg_pkg::lane_status_type          status
);

   localparam int STEP_W = $clog2(frwg_pkg::Q_BITS);
   localparam int AW     = frwg_pkg::PEAK_W + 2;
   localparam int REM_W  = AW + 1;

   typedef enum logic [1:0] {IDLE, SETUP, DIVIDE, DONE} phase_type;
   typedef enum logic [1:0] {DEG_ZERO, DEG_ONE, DEG_DIV} mode_type;

   phase_type phase_ff;
   logic [STEP_W-1:0] step_ff;
   logic signed [frwg_pkg::PEAK_W-1:0] x_ff;
   logic signed [frwg_pkg::PEAK_W-1:0] x_in;
   logic signed [frwg_pkg::PEAK_W-1:0] peak [N_SETS];
   mode_type mode_ff [N_SETS];
   mode_type mode_in [N_SETS];
   logic [REM_W-1:0] rem_ff [N_SETS];
   logic [REM_W-1:0] rem_in [N_SETS];
   logic [AW-1:0] den_ff [N_SETS];
   logic [AW-1:0] den_in [N_SETS];
   logic [frwg_pkg::Q_BITS-1:0] quo_ff [N_SETS];
   logic [REM_W-1:0] rem_step [N_SETS];
   logic [frwg_pkg::Q_BITS-1:0] quo_step [N_SETS];

   // Clamp low bound first, then high bound.
   always_comb begin
      x_in = sample;
      if (sample < peak[0]) begin
         x_in = peak[0];
      end
      if (x_in > peak[N_SETS-1]) begin
         x_in = peak[N_SETS-1];
      end
   end

   for (genvar s = 0; s < N_SETS; s++) begin : g_set
      logic signed [AW-1:0] mid, left, right, x, num, den;

      assign peak[s] = $signed(breakpoints[frwg_pkg::PEAK_W*s +: frwg_pkg::PEAK_W]);
      assign mid = AW'(peak[s]);
      assign x   = AW'(x_ff);

      if (s == 0) begin : g_lo
         assign left = AW'(peak[0]) - AW'(1);
      end else begin : g_lo_mid
         assign left = AW'(peak[s-1]);
      end
      if (s == N_SETS - 1) begin : g_hi
         assign right = AW'(peak[N_SETS-1]) + AW'(1);
      end else begin : g_hi_mid
         assign right = AW'(peak[s+1]);
      end

      always_comb begin
         num = '0;
         den = '0;
         if (x >= left && x <= mid) begin
            num = x - left;
            den = mid - left;
         end else if (x > mid && x <= right) begin
            num = right - x;
            den = right - mid;
         end
         if (den <= 0 || num <= 0) begin
            mode_in[s] = DEG_ZERO;
         end else if (num >= den) begin
            mode_in[s] = DEG_ONE;
         end else begin
            mode_in[s] = DEG_DIV;
         end
         rem_in[s] = REM_W'(unsigned'(num));
         den_in[s] = unsigned'(den);
      end

      // One restoring division step per cycle.
      always_comb begin
         logic [REM_W-1:0] shifted;
         shifted = {rem_ff[s][REM_W-2:0], 1'b0};
         if (shifted >= REM_W'(den_ff[s])) begin
            rem_step[s] = shifted - REM_W'(den_ff[s]);
            quo_step[s] = {quo_ff[s][frwg_pkg::Q_BITS-2:0], 1'b1};
         end else begin
            rem_step[s] = shifted;
            quo_step[s] = {quo_ff[s][frwg_pkg::Q_BITS-2:0], 1'b0};
         end
      end

      always_comb begin
         unique case (mode_ff[s])
            DEG_ONE: degree[s] = frwg_pkg::ONE_Q16;
            DEG_DIV: degree[s] = frwg_pkg::DEG_W'(quo_ff[s]);
            default: degree[s] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= IDLE;
      end else begin
         unique case (phase_ff)
            IDLE: begin
               if (start) begin
                  phase_ff <= SETUP;
               end
            end
            SETUP: begin
               phase_ff <= DIVIDE;
            end
            DIVIDE: begin
               if (step_ff == STEP_W'(frwg_pkg::Q_BITS - 1)) begin
                  phase_ff <= DONE;
               end
            end
            DONE: begin
               if (take) begin
                  phase_ff <= IDLE;
               end
            end
            default: phase_ff <= IDLE;
         endcase
      end
      if (phase_ff == IDLE && start) begin
         x_ff <= x_in;
      end
      if (phase_ff == SETUP) begin
         step_ff <= '0;
         for (int s = 0; s < N_SETS; s++) begin
            mode_ff[s] <= mode_in[s];
            rem_ff[s]  <= rem_in[s];
            den_ff[s]  <= den_in[s];
            quo_ff[s]  <= '0;
         end
      end else if (phase_ff == DIVIDE) begin
         step_ff <= step_ff + STEP_W'(1);
         for (int s = 0; s < N_SETS; s++) begin
            rem_ff[s] <= rem_step[s];
            quo_ff[s] <= quo_step[s];
         end
      end
   end

   assign status.busy = (phase_ff == SETUP) || (phase_ff == DIVIDE);
   assign status.done = (phase_ff == DONE);

endmodule

>>> src/frwg_rule_engine.sv
// Rule sweep: triple degree products, one weight per cycle unless stalled.
`timescale 1ns / 1ps

module frwg_rule_engine #(
   parameter int N_SETS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic [frwg_pkg::DEG_W-1:0]          deg_first  [N_SETS],
   input  logic [frwg_pkg::DEG_W-1:0]          deg_second [N_SETS],
   input  logic [frwg_pkg::DEG_W-1:0]          deg_third  [N_SETS],
   output logic                                can_load,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [frwg_pkg::IDX_W-1:0]          rsp_rule_index,
   output logic [frwg_pkg::WEIGHT_W-1:0]       rsp_firing_weight,
   output logic                                rsp_last_rule
);

   localparam int TOTAL  = N_SETS * N_SETS * N_SETS;
   localparam int RULE_W = $clog2(TOTAL);
   localparam int SEL_W  = $clog2(N_SETS);
   localparam int DW     = frwg_pkg::DEG_W;
   localparam int P1_W   = 2 * DW - 1;
   localparam int P2_W   = P1_W + DW;

   logic have_ff;
   logic [DW-1:0] deg_a_ff [N_SETS];
   logic [DW-1:0] deg_b_ff [N_SETS];
   logic [DW-1:0] deg_c_ff [N_SETS];
   logic [SEL_W-1:0] i_ff, j_ff, k_ff;
   logic [RULE_W-1:0] rule_ff;
   logic s1_valid_ff;
   logic [P1_W-1:0] s1_prod_ff;
   logic [DW-1:0] s1_c_ff;
   logic [RULE_W-1:0] s1_rule_ff;
   logic s1_last_ff;
   logic rsp_valid_ff;
   logic [frwg_pkg::WEIGHT_W-1:0] weight_ff;
   logic [frwg_pkg::IDX_W-1:0] index_ff;
   logic last_ff;
   logic advance, issue, last_issue;
   logic [P2_W-1:0] full_in;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign issue      = advance && have_ff;
   assign last_issue = (rule_ff == RULE_W'(TOTAL - 1));
   assign can_load   = !have_ff || (issue && last_issue);
   assign full_in    = P2_W'(s1_prod_ff) * P2_W'(s1_c_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            have_ff <= 1'b1;
         end else if (issue && last_issue) begin
            have_ff <= 1'b0;
         end
         if (advance) begin
            s1_valid_ff  <= issue;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         deg_a_ff <= deg_first;
         deg_b_ff <= deg_second;
         deg_c_ff <= deg_third;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         rule_ff  <= '0;
      end else if (issue) begin
         rule_ff <= rule_ff + RULE_W'(1);
         if (j_ff == SEL_W'(N_SETS - 1)) begin
            j_ff <= '0;
            if (i_ff == SEL_W'(N_SETS - 1)) begin
               i_ff <= '0;
               k_ff <= k_ff + SEL_W'(1);
            end else begin
               i_ff <= i_ff + SEL_W'(1);
            end
         end else begin
            j_ff <= j_ff + SEL_W'(1);
         end
      end
      if (advance) begin
         s1_prod_ff <= P1_W'(deg_a_ff[i_ff]) * P1_W'(deg_b_ff[j_ff]);
         s1_c_ff    <= deg_c_ff[k_ff];
         s1_rule_ff <= rule_ff;
         s1_last_ff <= last_issue;
         weight_ff  <= full_in[32 +: frwg_pkg::WEIGHT_W];
         index_ff   <= frwg_pkg::IDX_W'(s1_rule_ff);
         last_ff    <= s1_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rule_index    = index_ff;
   assign rsp_firing_weight = weight_ff;
   assign rsp_last_rule     = last_ff;

endmodule

>>> src/fuzzy_rule_weight_generator.sv
// Top level of the fuzzy rule weight generator.
`timescale 1ns / 1ps
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_valid / req_stall   three signed 16-bit samples
//   rsp      out        rsp_valid / rsp_stall   rule index, weight, last flag
//   csr      in         csr_wr_en               index (2 bits), 64-bit data
//
// An item is fuzzified by three lanes: each clamps its sample, sets up, and
// runs a one-bit-per-cycle restoring divider per set for the 16 quotient bits.
// The rule engine then emits N_SETS cubed weights, one per cycle unless rsp is
// stalled, through a two-stage multiplier pipeline; the lanes take the next
// item meanwhile. Reset is synchronous and restores the breakpoints to
// peaks 0,1,2,3. A stall on rsp holds the whole rule pipeline; req is
// stalled while the lanes are busy or hold degrees that the rule engine
// has not yet taken.

module fuzzy_rule_weight_generator #(
   parameter int N_SETS = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [frwg_pkg::SAMPLE_W-1:0]  req_sample_first,
   input  logic signed [frwg_pkg::SAMPLE_W-1:0]  req_sample_second,
   input  logic signed [frwg_pkg::SAMPLE_W-1:0]  req_sample_third,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [frwg_pkg::IDX_W-1:0]            rsp_rule_index,
   output logic [frwg_pkg::WEIGHT_W-1:0]         rsp_firing_weight,
   output logic                                  rsp_last_rule,
   input  logic                                  csr_wr_en,
   input  logic [frwg_pkg::CSR_W-1:0]            csr_index,
   input  logic [frwg_pkg::BP_W-1:0]             csr_wdata
);

   logic [frwg_pkg::BP_W-1:0] bp_ff [frwg_pkg::N_INPUTS];
   logic signed [frwg_pkg::SAMPLE_W-1:0] sample [frwg_pkg::N_INPUTS];
   logic [frwg_pkg::DEG_W-1:0] degree [frwg_pkg::N_INPUTS][N_SETS];
   frwg_pkg::lane_status_type lane_st [frwg_pkg::N_INPUTS];
   logic accept, load, can_load, front_full;

   // Breakpoint registers; writes to an index beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < frwg_pkg::N_INPUTS; n++) begin
            bp_ff[n] <= frwg_pkg::BP_RESET;
         end
      end else if (csr_wr_en) begin
         unique case (csr_index)
            frwg_pkg::CSR_BP_FIRST:  bp_ff[0] <= csr_wdata;
            frwg_pkg::CSR_BP_SECOND: bp_ff[1] <= csr_wdata;
            frwg_pkg::CSR_BP_THIRD:  bp_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign sample[0] = req_sample_first;
   assign sample[1] = req_sample_second;
   assign sample[2] = req_sample_third;

   // The lanes run in lockstep, so any of them describes the front end.
   assign front_full = lane_st[0].busy || lane_st[0].done;
   assign req_stall  = front_full;
   assign accept     = req_valid && !req_stall;
   assign load       = lane_st[0].done && can_load;

   for (genvar n = 0; n < frwg_pkg::N_INPUTS; n++) begin : g_lane
      frwg_lane #(.N_SETS(N_SETS)) u_lane (
         .clock       (clock),
         .reset       (reset),
         .start       (accept),
         .take        (load),
         .breakpoints (bp_ff[n]),
         .sample      (sample[n]),
         .degree      (degree[n]),
         .status      (lane_st[n])
      );
   end

   frwg_rule_engine #(.N_SETS(N_SETS)) u_engine (
      .clock             (clock),
      .reset             (reset),
      .load              (load),
      .deg_first         (degree[0]),
      .deg_second        (degree[1]),
      .deg_third         (degree[2]),
      .can_load          (can_load),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_rule_index    (rsp_rule_index),
      .rsp_firing_weight (rsp_firing_weight),
      .rsp_last_rule     (rsp_last_rule)
   );

`ifndef SYNTHESIS
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      lane_st[0] == lane_st[1] && lane_st[0] == lane_st[2])
      else $error("fuzzification lanes out of step");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> lane_st[0].busy)
      else $error("accepted item did not start the lanes");

   a_weight_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_firing_weight <= frwg_pkg::WEIGHT_W'(65536))
      else $error("firing weight above one");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_rule |->
         rsp_rule_index == frwg_pkg::IDX_W'(N_SETS * N_SETS * N_SETS - 1))
      else $error("last flag on a rule that is not the final one");
`endif

endmodule

>>> sim/fuzzy_rule_weight_generator_tb.sv
// Self-checking testbench for the fuzzy rule weight generator.
`timescale 1ns / 1ps

module fuzzy_rule_weight_generator_tb;

   localparam int SETS      = 4;
   localparam int RULES     = SETS * SETS * SETS;
   localparam int LIMIT     = 400000;
   localparam int DRAIN     = 60;

   // Register index that names no breakpoint register.
   localparam logic [frwg_pkg::CSR_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [frwg_pkg::IDX_W-1:0]    rule;
      logic [frwg_pkg::WEIGHT_W-1:0] weight;
      logic                          last;
   } rule_weight_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [frwg_pkg::SAMPLE_W-1:0] req_sample_first = '0;
   logic signed [frwg_pkg::SAMPLE_W-1:0] req_sample_second = '0;
   logic signed [frwg_pkg::SAMPLE_W-1:0] req_sample_third = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [frwg_pkg::IDX_W-1:0] rsp_rule_index;
   logic [frwg_pkg::WEIGHT_W-1:0] rsp_firing_weight;
   logic rsp_last_rule;
   logic csr_wr_en = 1'b0;
   logic [frwg_pkg::CSR_W-1:0] csr_index = '0;
   logic [frwg_pkg::BP_W-1:0] csr_wdata = '0;

   // Testbench copy of the three breakpoint registers.
   logic [frwg_pkg::BP_W-1:0] peaks_model [frwg_pkg::N_INPUTS];

   // Weights still owed by the block, oldest first.
   rule_weight_type weights_due[$];

   int errors = 0;
   int items_sent = 0;
   int weights_seen = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off = 1'b0;

   fuzzy_rule_weight_generator #(.N_SETS(SETS)) dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // The run is cut off if it ever exceeds a generous cycle budget.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver back-pressure. A long hold-off overrides the random stall so
   // that the block backs up all the way to its input.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("Mismatch on %s at cycle %0d: got %0d, expected %0d",
               what, cycle_count, got, want);
   endtask

   // Membership degree of one sample in one set, in Q1.16.
   function automatic int unsigned degree_ratio(input int num, input int den);
      longint unsigned q;
      if (den <= 0 || num <= 0) return 0;
      if (num >= den) return 65536;
      q = (longint'(num) << 16) / den;
      return int'(q);
   endfunction

   function automatic void fuzzify_sample(input logic [frwg_pkg::BP_W-1:0] bp,
                                          input logic signed [frwg_pkg::SAMPLE_W-1:0] sample,
                                          output int unsigned deg [SETS]);
      int p [SETS];
      int x, lo, hi;
      for (int s = 0; s < SETS; s++) p[s] = int'($signed(bp[16*s +: 16]));
      x = int'(sample);
      // The low bound is applied first so the last peak wins when unordered.
      if (x < p[0]) x = p[0];
      if (x > p[SETS-1]) x = p[SETS-1];
      for (int s = 0; s < SETS; s++) begin
         lo = (s == 0) ? p[0] - 1 : p[s-1];
         hi = (s == SETS-1) ? p[SETS-1] + 1 : p[s+1];
         if (x >= lo && x <= p[s]) deg[s] = degree_ratio(x - lo, p[s] - lo);
         else if (x > p[s] && x <= hi) deg[s] = degree_ratio(hi - x, hi - p[s]);
         else deg[s] = 0;
      end
   endfunction

   // Queues every rule weight that one sample triple should produce.
   function automatic void predict_rule_weights(
         input logic signed [frwg_pkg::SAMPLE_W-1:0] a,
         input logic signed [frwg_pkg::SAMPLE_W-1:0] b,
         input logic signed [frwg_pkg::SAMPLE_W-1:0] c);
      int unsigned da [SETS], db [SETS], dc [SETS];
      logic [95:0] prod;
      rule_weight_type w;
      fuzzify_sample(peaks_model[0], a, da);
      fuzzify_sample(peaks_model[1], b, db);
      fuzzify_sample(peaks_model[2], c, dc);
      for (int r = 0; r < RULES; r++) begin
         prod = 96'(da[(r / SETS) % SETS]) * 96'(db[r % SETS]) * 96'(dc[r / (SETS*SETS)]);
         w.rule = frwg_pkg::IDX_W'(r);
         w.weight = frwg_pkg::WEIGHT_W'(prod >> 32);
         w.last = (r == RULES - 1);
         weights_due.insert(weights_due.size(), w);
      end
   endfunction

   // Result checker: every accepted weight is matched against the oldest one owed.
   always @(posedge clock) begin
      rule_weight_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         weights_seen++;
         if (weights_due.size() == 0) begin
            report_mismatch("rule_index with no weight owed", rsp_rule_index, -1);
         end else begin
            want = weights_due.pop_front();
            if (rsp_rule_index !== want.rule)
               report_mismatch("rule_index", rsp_rule_index, want.rule);
            if (rsp_firing_weight !== want.weight)
               report_mismatch("firing_weight", rsp_firing_weight, want.weight);
            if (rsp_last_rule !== want.last)
               report_mismatch("last_rule", rsp_last_rule, want.last);
         end
      end
   end

   // Offers one item, with a random gap first, and waits until it is taken.
   // Valid stays high after the accepting edge; the next item or a drain
   // replaces it at the following falling edge.
   task automatic send_samples(input logic signed [frwg_pkg::SAMPLE_W-1:0] a,
                               input logic signed [frwg_pkg::SAMPLE_W-1:0] b,
                               input logic signed [frwg_pkg::SAMPLE_W-1:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_first <= a;
      req_sample_second <= b;
      req_sample_third <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_rule_weights(a, b, c);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (weights_due.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   // Register writes happen only with the pipeline empty.
   task automatic write_breakpoints(input logic [frwg_pkg::CSR_W-1:0] idx,
                                    input logic [frwg_pkg::BP_W-1:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx < frwg_pkg::N_INPUTS) peaks_model[idx] = value;
   endtask

   function automatic logic [frwg_pkg::BP_W-1:0] pack_peaks(input int p0, input int p1,
                                                            input int p2, input int p3);
      return {16'(p3), 16'(p2), 16'(p1), 16'(p0)};
   endfunction

   function automatic logic signed [frwg_pkg::SAMPLE_W-1:0] random_sample();
      unique case ($urandom_range(3))
         0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         1: return frwg_pkg::SAMPLE_W'($urandom_range(20)) - 16'sd5;
         default: return frwg_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   // Extremes of the samples at the default peaks 0..3.
   task automatic test_reset_peaks();
      send_samples(16'sh8000, 16'sh7fff, 16'sd0);
      send_samples(16'sd1, 16'sd2, 16'sd3);
      send_samples(16'sh7fff, 16'sh8000, -16'sd1);
      send_samples(16'shffff, 16'sh5555, 16'shaaaa);
   endtask

   // Wide, repeated, unordered and full-range breakpoints.
   task automatic test_special_peaks();
      write_breakpoints(frwg_pkg::CSR_BP_FIRST, pack_peaks(-1000, -10, 10, 1000));
      write_breakpoints(frwg_pkg::CSR_BP_SECOND, pack_peaks(5, 5, 5, 9));
      write_breakpoints(frwg_pkg::CSR_BP_THIRD, pack_peaks(300, 200, 100, 0));
      send_samples(-16'sd500, 16'sd5, 16'sd150);
      send_samples(16'sd0, 16'sd7, 16'sd300);
      send_samples(16'sd999, 16'sd9, -16'sd7);
      write_breakpoints(frwg_pkg::CSR_BP_FIRST, pack_peaks(-32768, -1, 0, 32767));
      write_breakpoints(frwg_pkg::CSR_BP_SECOND, 64'hffff_ffff_ffff_ffff);
      write_breakpoints(frwg_pkg::CSR_BP_THIRD, pack_peaks(-32768, -16384, 16384, 32767));
      send_samples(16'sh8000, 16'sh8000, 16'sh7fff);
      send_samples(16'sd12345, 16'sd0, -16'sd1);
      // An index past the last register must leave the peaks untouched.
      write_breakpoints(CSR_UNUSED, 64'h0123_4567_89ab_cdef);
      send_samples(-16'sd20000, 16'sd1, 16'sd20000);
   endtask

   // Random samples over a set of random and structured breakpoints.
   task automatic test_random_items(input int count, input int snd, input int rcv);
      int base, step;
      for (int n = 0; n < frwg_pkg::N_INPUTS; n++) begin
         base = int'($urandom_range(60000)) - 32768;
         step = $urandom_range(3) == 0 ? 0 : $urandom_range(1500);
         write_breakpoints(frwg_pkg::CSR_W'(int'(frwg_pkg::CSR_BP_FIRST) + n),
            $urandom_range(4) == 0 ?
            {$urandom, $urandom} :
            pack_peaks(base, base + step, base + 2*step, base + 3*step));
      end
      send_idle_pct = snd;
      recv_idle_pct = rcv;
      for (int i = 0; i < count; i++) send_samples(random_sample(), random_sample(), random_sample());
   endtask

   // Receiver holds off for a long stretch while items keep coming.
   task automatic test_back_pressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off = 1'b1;
      fork
         begin
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
      join_none
      for (int i = 0; i < 5; i++) send_samples(random_sample(), random_sample(), random_sample());
   endtask

   initial begin
      for (int n = 0; n < frwg_pkg::N_INPUTS; n++) peaks_model[n] = frwg_pkg::BP_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_peaks();
      test_special_peaks();
      for (int p = 0; p < 6; p++) test_random_items(10, 11, 75);
      for (int p = 0; p < 6; p++) test_random_items(10, 75, 11);
      for (int p = 0; p < 5; p++) test_random_items(10, 0, 0);
      test_back_pressure();

      wait_drained();
      $display("Sent %0d items and checked %0d rule weights over several breakpoint sets,",
               items_sent, weights_seen);
      $display("including unordered, repeated and full-range peaks and a long output stall.");
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
